// ----- sv/log_page_readout_sequencer_defines.svh -----
// Assertion macros used by the log page readout sequencer top level.
`ifndef LOG_PAGE_READOUT_SEQUENCER_DEFINES_SVH
`define LOG_PAGE_READOUT_SEQUENCER_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define LPRS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lprs assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define LPRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lprs assertion failed");

`endif

// ----- sv/lprs_pkg.sv -----
// Types and constants of the log page readout sequencer.
package lprs_pkg;

	// transaction codes of responses
	localparam logic [15:0] TXN_LOG_STATE = 16'h0CC0;
	localparam logic [15:0] TXN_LOG_PAGE  = 16'hC0C0;
	localparam logic [15:0] TXN_LOG_RESET = 16'hFCFC;

	localparam logic [15:0] RESET_WORDS  = 16'd2;
	localparam logic [15:0] STATE_OFFSET = 16'd4;
	localparam logic [15:0] WRAP_RESET   = 16'd100;

	// configuration port
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_LOG_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WRAP     = 1'b1;

	// steps of the shift/add unit, one per operand bit
	localparam int ALU_STEPS = 16;
	localparam int ALU_CNT_W = $clog2(ALU_STEPS);

	localparam logic ACT_DISCONNECT = 1'b0;
	localparam logic ACT_RESPONSE   = 1'b1;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_EXCEPTION   = 2'd1,
		ST_UNKNOWN_TXN = 2'd2,
		ST_ZERO_PAGE   = 2'd3
	} status_t;

	typedef enum logic {
		REQ_READ_PAGE = 1'b0,
		REQ_RESET_LOG = 1'b1
	} req_kind_t;

	typedef enum logic {
		ALU_DIV = 1'b0,
		ALU_MUL = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic        action;
		logic [15:0] transaction_code;
		logic [7:0]  function_code;
		logic [15:0] log_start_address;
		logic [15:0] log_end_address;
		logic [15:0] log_page_words;
	} lprs_in_t;

	typedef struct packed {
		logic        request_valid;
		req_kind_t   request_kind;
		logic [15:0] request_start;
		logic [15:0] request_words;
		logic        page_slot_valid;
		logic [15:0] page_slot;
		logic        readout_done;
		status_t     status;
	} lprs_out_t;

	// command to the shift/add unit
	typedef struct packed {
		logic        go;
		alu_op_t     op;
		logic [15:0] opa;
		logic [15:0] opb;
		logic [15:0] acc_init;
	} lprs_alu_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] result;
	} lprs_alu_rsp_t;

endpackage

// ----- sv/lprs_in_if.sv -----
// Event channel into the log page readout sequencer.
interface lprs_in_if;
	logic               valid;
	logic               ready;
	lprs_pkg::lprs_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/lprs_out_if.sv -----
// Result channel out of the log page readout sequencer.
interface lprs_out_if;
	logic                valid;
	logic                ready;
	lprs_pkg::lprs_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/log_page_readout_sequencer.sv -----
// Top level of the log page readout sequencer.
//
// One event word in gives one result word out. Events that need no arithmetic
// (link drop, exception, reset acknowledge, unknown code, the last page, a
// log state that needs no division) go from acceptance straight to the finish
// state; the block drops ready after acceptance and is ready again once the
// result has moved into the output register. A log state that starts a readout
// from page size, and every page that requests a further page, go through one
// shared shift/add unit that runs one step per operand bit on the division of
// end address by page size or on the product of next page index and page size
// added to the page base. The result sits in an output register, so the next
// event is taken while it waits; a result that finds the output register still
// full holds the block until it is taken. Configuration must be written only
// while no event is in flight; the block itself does not enforce it.
`include "log_page_readout_sequencer_defines.svh"

module log_page_readout_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lprs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lprs_pkg::CFG_W-1:0]     cfg_wdata,
	lprs_in_if.sink                       evt,
	lprs_out_if.source                    res
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_MUL,
		S_FIN
	} state_t;

	state_t              state_q;
	logic [15:0]         log_base_q;
	logic [15:0]         wrap_count_q;
	logic                active_q;
	logic [15:0]         page_index_q;
	logic [15:0]         pages_total_q;
	logic [15:0]         saved_pw_q;
	lprs_pkg::lprs_out_t res_q;
	lprs_pkg::lprs_out_t out_q;
	logic                out_valid_q;

	lprs_pkg::lprs_in_t      d;
	lprs_pkg::lprs_alu_req_t alu_req;
	lprs_pkg::lprs_alu_rsp_t alu_rsp;

	logic        accept;
	logic        is_resp;
	logic        is_exc;
	logic        is_state;
	logic        is_page;
	logic        begin_rd;
	logic        need_div;
	logic        need_mul;
	logic        page_last;
	logic [15:0] idx_inc;
	logic [15:0] page_base;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_base_q   <= '0;
			wrap_count_q <= lprs_pkg::WRAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lprs_pkg::CFG_LOG_BASE: log_base_q   <= cfg_wdata;
				lprs_pkg::CFG_WRAP:     wrap_count_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// decode the incoming word
	always_comb begin
		d         = evt.data;
		accept    = evt.valid && evt.ready;
		is_resp   = d.action == lprs_pkg::ACT_RESPONSE;
		is_exc    = d.function_code[7];
		is_state  = is_resp && !is_exc && d.transaction_code == lprs_pkg::TXN_LOG_STATE;
		is_page   = is_resp && !is_exc && d.transaction_code == lprs_pkg::TXN_LOG_PAGE;
		begin_rd  = is_state && !active_q &&
		            (d.log_start_address != 16'd0 || d.log_end_address != 16'd0);
		need_div  = begin_rd && d.log_start_address == 16'd0 && d.log_page_words != 16'd0;
		idx_inc   = page_index_q + 16'd1;
		page_last = idx_inc >= pages_total_q;
		need_mul  = is_page && !page_last;
		page_base = log_base_q + lprs_pkg::STATE_OFFSET;
	end

	// start the shared unit on acceptance
	always_comb begin
		alu_req.go       = accept && (need_div || need_mul);
		alu_req.op       = need_div ? lprs_pkg::ALU_DIV : lprs_pkg::ALU_MUL;
		alu_req.opa      = need_div ? d.log_end_address : idx_inc;
		alu_req.opb      = need_div ? d.log_page_words : saved_pw_q;
		alu_req.acc_init = page_base;
	end

	lprs_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	// sequence one event at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			active_q      <= 1'b0;
			page_index_q  <= '0;
			pages_total_q <= '0;
			saved_pw_q    <= '0;
			res_q         <= '0;
			out_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			// drop a word once taken unless a new one replaces it
			if (res.ready && state_q != S_FIN)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= need_div ? S_DIV : (need_mul ? S_MUL : S_FIN);
						if (!is_resp) begin
							active_q      <= 1'b0;
							page_index_q  <= '0;
							pages_total_q <= '0;
						end else if (is_exc) begin
							res_q.status <= lprs_pkg::ST_EXCEPTION;
						end else begin
							case (d.transaction_code)
								lprs_pkg::TXN_LOG_STATE: begin
									saved_pw_q <= d.log_page_words;
									if (begin_rd) begin
										active_q     <= 1'b1;
										page_index_q <= '0;
										if (d.log_start_address != 16'd0) begin
											pages_total_q <= wrap_count_q;
											if (wrap_count_q != 16'd0) begin
												res_q.request_valid <= 1'b1;
												res_q.request_kind  <= lprs_pkg::REQ_READ_PAGE;
												res_q.request_start <= page_base;
												res_q.request_words <= d.log_page_words;
											end
										end else if (d.log_page_words == 16'd0) begin
											pages_total_q <= '0;
											res_q.status  <= lprs_pkg::ST_ZERO_PAGE;
										end
									end
								end
								lprs_pkg::TXN_LOG_PAGE: begin
									res_q.page_slot_valid <= 1'b1;
									res_q.page_slot       <= page_index_q;
									if (page_last) begin
										active_q            <= 1'b0;
										page_index_q        <= '0;
										pages_total_q       <= '0;
										res_q.readout_done  <= 1'b1;
										res_q.request_valid <= 1'b1;
										res_q.request_kind  <= lprs_pkg::REQ_RESET_LOG;
										res_q.request_start <= log_base_q;
										res_q.request_words <= lprs_pkg::RESET_WORDS;
									end else begin
										page_index_q        <= idx_inc;
										res_q.request_valid <= 1'b1;
										res_q.request_kind  <= lprs_pkg::REQ_READ_PAGE;
										res_q.request_words <= saved_pw_q;
									end
								end
								lprs_pkg::TXN_LOG_RESET: ;
								default: res_q.status <= lprs_pkg::ST_UNKNOWN_TXN;
							endcase
						end
					end
				end
				S_DIV: begin
					// page count from end address over page size
					if (alu_rsp.done) begin
						pages_total_q <= alu_rsp.result;
						if (alu_rsp.result != 16'd0) begin
							res_q.request_valid <= 1'b1;
							res_q.request_kind  <= lprs_pkg::REQ_READ_PAGE;
							res_q.request_start <= page_base;
							res_q.request_words <= saved_pw_q;
						end
						state_q <= S_FIN;
					end
				end
				S_MUL: begin
					// page address already holds base and offset
					if (alu_rsp.done) begin
						res_q.request_start <= alu_rsp.result;
						state_q             <= S_FIN;
					end
				end
				S_FIN: begin
					// hand the word over and clear it for the next event
					if (!out_valid_q || res.ready) begin
						out_q       <= res_q;
						res_q       <= '0;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign evt.ready = state_q == S_IDLE;
	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	// the unit only reports back while a calculation is awaited
	`LPRS_ASSERT_SAME(a_done_in_calc, clk, arst_n, alu_rsp.done, (state_q == S_DIV || state_q == S_MUL))
	// an accepted word never collides with a unit result
	`LPRS_ASSERT_SAME(a_accept_quiet, clk, arst_n, accept, !alu_rsp.done)
	// a finished result reaches the output register when there is room
	`LPRS_ASSERT_NEXT(a_fin_loads, clk, arst_n, (state_q == S_FIN && (!out_valid_q || res.ready)), (res.valid && state_q == S_IDLE))
	// a finished readout always carries the log reset request
	`LPRS_ASSERT_SAME(a_done_resets, clk, arst_n, (res.valid && res.data.readout_done), (res.data.request_valid && res.data.request_kind == lprs_pkg::REQ_RESET_LOG))

endmodule

// ----- sv/lprs_alu.sv -----
// Shared shift/add unit: restoring 16-bit divide or 16-bit multiply-accumulate.
module lprs_alu (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lprs_pkg::lprs_alu_req_t req,
	output lprs_pkg::lprs_alu_rsp_t rsp
);

	logic                         busy_q;
	logic                         done_q;
	lprs_pkg::alu_op_t            op_q;
	logic [lprs_pkg::ALU_CNT_W-1:0] cnt_q;
	logic [16:0]                  acc_q;
	logic [15:0]                  a_q;
	logic [15:0]                  b_q;

	logic [16:0] shifted;
	logic [16:0] add_x;
	logic [16:0] add_y;
	logic        add_sub;
	logic [17:0] sum;
	logic        ge;

	// share one adder: subtract for divide, add for multiply
	always_comb begin
		shifted = {acc_q[15:0], a_q[15]};
		if (op_q == lprs_pkg::ALU_DIV) begin
			add_x   = shifted;
			add_y   = {1'b0, b_q};
			add_sub = 1'b1;
		end else begin
			add_x   = {1'b0, acc_q[15:0]};
			add_y   = {1'b0, a_q};
			add_sub = 1'b0;
		end
		sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + {17'd0, add_sub};
		ge  = sum[17];
	end

	// load operands, then run one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= lprs_pkg::ALU_DIV;
			cnt_q  <= '0;
			acc_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
		end else begin
			// flag the last step
			done_q <= busy_q && (cnt_q == lprs_pkg::ALU_CNT_W'(lprs_pkg::ALU_STEPS - 1));
			if (req.go && !busy_q) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= '0;
				a_q    <= req.opa;
				b_q    <= req.opb;
				acc_q  <= (req.op == lprs_pkg::ALU_DIV) ? 17'd0 : {1'b0, req.acc_init};
			end else if (busy_q) begin
				if (op_q == lprs_pkg::ALU_DIV) begin
					acc_q <= ge ? sum[16:0] : shifted;
					a_q   <= {a_q[14:0], ge};
				end else begin
					if (b_q[0])
						acc_q <= {1'b0, sum[15:0]};
					a_q <= {a_q[14:0], 1'b0};
					b_q <= {1'b0, b_q[15:1]};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == lprs_pkg::ALU_CNT_W'(lprs_pkg::ALU_STEPS - 1))
					busy_q <= 1'b0;
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = (op_q == lprs_pkg::ALU_DIV) ? a_q : acc_q[15:0];

endmodule
